// ===== hdl/tcc_pkg.sv =====
package tcc_pkg;

	// widths of the configuration port
	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 13;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_TERM_COLS = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TERM_ROWS = 4'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FONT_W    = 4'd2;
	localparam logic [CFG_IDX_W-1:0] REG_FONT_H    = 4'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SCREEN_W  = 4'd4;
	localparam logic [CFG_IDX_W-1:0] REG_SCREEN_H  = 4'd5;
	localparam logic [CFG_IDX_W-1:0] REG_WIN_X     = 4'd6;
	localparam logic [CFG_IDX_W-1:0] REG_WIN_Y     = 4'd7;

	// register values after reset
	localparam logic [9:0]  RST_TERM_COLS = 10'd80;
	localparam logic [8:0]  RST_TERM_ROWS = 9'd25;
	localparam logic [5:0]  RST_FONT_W    = 6'd8;
	localparam logic [6:0]  RST_FONT_H    = 7'd16;
	localparam logic [12:0] RST_SCREEN_W  = 13'd640;
	localparam logic [12:0] RST_SCREEN_H  = 13'd400;
	localparam logic [11:0] RST_WIN_X     = 12'd0;
	localparam logic [11:0] RST_WIN_Y     = 12'd0;

	// framebuffer command codes
	localparam logic [1:0] CMD_HIDE   = 2'd0;
	localparam logic [1:0] CMD_DRAW   = 2'd1;
	localparam logic [1:0] CMD_SCROLL = 2'd2;
	localparam logic [1:0] CMD_SHOW   = 2'd3;

	// control characters
	localparam logic [7:0] CH_NL    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_BS    = 8'h08;
	localparam logic [7:0] CH_SPACE = 8'h20;

	// character class decided by the front end
	typedef enum logic [1:0] {
		KIND_PRINT = 2'd0,
		KIND_NL    = 2'd1,
		KIND_CR    = 2'd2,
		KIND_BS    = 2'd3
	} kind_t;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] glyph;
	} item_t;

	// queue head as seen by the back end
	typedef struct packed {
		logic  valid;
		item_t item;
	} q_head_t;

	typedef struct packed {
		logic [9:0]  term_cols;
		logic [8:0]  term_rows;
		logic [5:0]  font_w;
		logic [6:0]  font_h;
		logic [12:0] screen_w;
		logic [12:0] screen_h;
		logic [11:0] win_x;
		logic [11:0] win_y;
	} cfg_t;

endpackage

// ===== hdl/tcc_front.sv =====
module tcc_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [7:0]        ch,
	input  logic              pop,
	output tcc_pkg::q_head_t  head
);
	import tcc_pkg::*;

	item_t      cls;
	item_t      slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	logic       push;

	// classify the incoming character
	always_comb begin
		cls.glyph = ch;
		unique case (ch)
			CH_NL:   cls.kind = KIND_NL;
			CH_CR:   cls.kind = KIND_CR;
			CH_BS:   cls.kind = KIND_BS;
			default: cls.kind = KIND_PRINT;
		endcase
	end

	assign in_ready   = (cnt_q != 2'd2);
	assign push       = in_valid && in_ready;
	assign head.valid = (cnt_q != 2'd0);
	assign head.item  = slot_q[rd_ptr_q];

	// two-entry queue pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push)
				wr_ptr_q <= ~wr_ptr_q;
			if (pop)
				rd_ptr_q <= ~rd_ptr_q;
			if (push && !pop)
				cnt_q <= cnt_q + 2'd1;
			else if (pop && !push)
				cnt_q <= cnt_q - 2'd1;
		end
	end

	// queue storage
	always_ff @(posedge clk) begin
		if (push)
			slot_q[wr_ptr_q] <= cls;
	end

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> (cnt_q != 2'd0))
		else $error("pop from empty queue");

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3)
		else $error("queue fill level out of range");

	a_cnt_push: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> (cnt_q == $past(cnt_q) + 2'd1))
		else $error("queue fill level lost a transfer");

endmodule

// ===== hdl/tcc_back.sv =====
module tcc_back (
	input  logic              clk,
	input  logic              arst_n,
	input  tcc_pkg::cfg_t     cfg,
	input  logic              cfg_wr,
	input  tcc_pkg::q_head_t  head,
	output logic              pop,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [1:0]        cmd,
	output logic [11:0]       px,
	output logic [11:0]       py,
	output logic [7:0]        glyph,
	output logic              last
);
	import tcc_pkg::*;

	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_POS  = 6'b000010,
		ST_HIDE = 6'b000100,
		ST_DRAW = 6'b001000,
		ST_MOVE = 6'b010000,
		ST_SHOW = 6'b100000
	} state_t;

	state_t      state_q;
	logic [8:0]  col_q;
	logic [7:0]  row_q;
	logic        shown_q;
	logic        coord_ok_q;
	logic        phase_q;
	kind_t       kind_q;
	logic [7:0]  glyph_q;
	logic [16:0] cx_q;
	logic [16:0] cy_q;

	logic        out_v_q;
	logic [1:0]  out_cmd_q;
	logic [11:0] out_px_q;
	logic [11:0] out_py_q;
	logic [7:0]  out_glyph_q;
	logic        out_last_q;

	logic [9:0]  cols_eff;
	logic [8:0]  rows_eff;
	logic [7:0]  last_row;
	logic [16:0] fw17, fh17, sw17, sh17, winx17;
	logic [14:0] mx, my;
	logic [16:0] pos_x, pos_y;
	logic [9:0]  nc;
	logic [8:0]  nr;
	logic        col_ok, row_ok, bs_step, fits;
	logic [16:0] dx;

	logic        emit_req;
	logic [1:0]  e_cmd;
	logic [11:0] e_px, e_py;
	logic [7:0]  e_glyph;
	logic        e_last;
	logic        slot, adv;

	// window size clamped to the state widths
	always_comb begin
		cols_eff = cfg.term_cols;
		if (cfg.term_cols == 10'd0)
			cols_eff = 10'd1;
		else if (cfg.term_cols > 10'd512)
			cols_eff = 10'd512;
		rows_eff = cfg.term_rows;
		if (cfg.term_rows == 9'd0)
			rows_eff = 9'd1;
		else if (cfg.term_rows > 9'd256)
			rows_eff = 9'd256;
	end

	assign last_row = 8'(rows_eff - 9'd1);
	assign fw17     = {11'b0, cfg.font_w};
	assign fh17     = {10'b0, cfg.font_h};
	assign sw17     = {4'b0, cfg.screen_w};
	assign sh17     = {4'b0, cfg.screen_h};
	assign winx17   = {5'b0, cfg.win_x};

	// cell origin from column and row
	assign mx    = {6'b0, col_q} * {9'b0, cfg.font_w};
	assign my    = {7'b0, row_q} * {8'b0, cfg.font_h};
	assign pos_x = winx17 + {2'b0, mx};
	assign pos_y = {5'b0, cfg.win_y} + {2'b0, my};

	// advance checks against the registered cell origin
	assign nc      = {1'b0, col_q} + 10'd1;
	assign nr      = {1'b0, row_q} + 9'd1;
	assign col_ok  = (nc < cols_eff) && ((cx_q + fw17) < sw17);
	assign row_ok  = (nr < rows_eff) && ((cy_q + fh17) < sh17);
	assign bs_step = (kind_q == KIND_BS) && (col_q != 9'd0);
	assign dx      = bs_step ? (cx_q - fw17) : cx_q;
	assign fits    = (dx < sw17) && (cy_q < sh17) &&
	                 ((dx + fw17) <= sw17) && ((cy_q + fh17) <= sh17);

	// command produced in the current step
	always_comb begin
		emit_req = 1'b0;
		e_cmd    = CMD_HIDE;
		e_px     = cx_q[11:0];
		e_py     = cy_q[11:0];
		e_glyph  = 8'd0;
		e_last   = 1'b0;
		unique case (state_q)
			ST_HIDE: emit_req = 1'b1;
			ST_DRAW: begin
				if ((kind_q == KIND_PRINT || kind_q == KIND_BS) && fits) begin
					emit_req = 1'b1;
					e_cmd    = CMD_DRAW;
					e_px     = dx[11:0];
					e_glyph  = (kind_q == KIND_BS) ? CH_SPACE : glyph_q;
				end
			end
			ST_MOVE: begin
				if (!(kind_q == KIND_PRINT && col_ok) && !row_ok) begin
					emit_req = 1'b1;
					e_cmd    = CMD_SCROLL;
					e_px     = 12'd0;
					e_py     = 12'd0;
				end
			end
			ST_SHOW: begin
				emit_req = 1'b1;
				e_cmd    = CMD_SHOW;
				e_last   = 1'b1;
			end
			default: ;
		endcase
	end

	assign slot = !out_v_q || out_ready;
	assign adv  = !emit_req || slot;
	assign pop  = adv && head.valid && (state_q == ST_IDLE || state_q == ST_SHOW);

	// sequencer and cursor state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			col_q      <= 9'd0;
			row_q      <= 8'd0;
			shown_q    <= 1'b0;
			coord_ok_q <= 1'b0;
			phase_q    <= 1'b0;
			out_v_q    <= 1'b0;
		end else begin
			if (slot)
				out_v_q <= emit_req;
			if (cfg_wr)
				coord_ok_q <= 1'b0;
			if (adv) begin
				unique case (state_q)
					ST_IDLE: begin
						if (head.valid) begin
							if (!coord_ok_q)
								state_q <= ST_POS;
							else
								state_q <= shown_q ? ST_HIDE : ST_DRAW;
						end
					end
					ST_POS: begin
						coord_ok_q <= 1'b1;
						if (phase_q)
							state_q <= ST_SHOW;
						else
							state_q <= shown_q ? ST_HIDE : ST_DRAW;
					end
					ST_HIDE: begin
						shown_q <= 1'b0;
						state_q <= ST_DRAW;
					end
					ST_DRAW: begin
						case (kind_q)
							KIND_CR: begin
								col_q   <= 9'd0;
								state_q <= ST_SHOW;
							end
							KIND_BS: begin
								if (bs_step)
									col_q <= col_q - 9'd1;
								state_q <= ST_SHOW;
							end
							default: state_q <= ST_MOVE;
						endcase
					end
					ST_MOVE: begin
						if (kind_q == KIND_PRINT && col_ok) begin
							col_q   <= nc[8:0];
							state_q <= ST_SHOW;
						end else begin
							col_q <= 9'd0;
							if (row_ok) begin
								row_q   <= nr[7:0];
								state_q <= ST_SHOW;
							end else begin
								row_q   <= last_row;
								phase_q <= 1'b1;
								state_q <= ST_POS;
							end
						end
					end
					ST_SHOW: begin
						shown_q <= 1'b1;
						phase_q <= 1'b0;
						if (head.valid)
							state_q <= coord_ok_q ? ST_HIDE : ST_POS;
						else
							state_q <= ST_IDLE;
					end
					default: state_q <= ST_IDLE;
				endcase
			end
		end
	end

	// item, cell origin and output payload
	always_ff @(posedge clk) begin
		if (pop) begin
			kind_q  <= head.item.kind;
			glyph_q <= head.item.glyph;
		end
		if (adv) begin
			case (state_q)
				ST_POS: begin
					cx_q <= pos_x;
					cy_q <= pos_y;
				end
				ST_DRAW: begin
					if (kind_q == KIND_CR)
						cx_q <= winx17;
					else if (kind_q == KIND_BS)
						cx_q <= dx;
				end
				ST_MOVE: begin
					if (kind_q == KIND_PRINT && col_ok) begin
						cx_q <= cx_q + fw17;
					end else begin
						cx_q <= winx17;
						if (row_ok)
							cy_q <= cy_q + fh17;
					end
				end
				default: ;
			endcase
		end
		if (slot && emit_req) begin
			out_cmd_q   <= e_cmd;
			out_px_q    <= e_px;
			out_py_q    <= e_py;
			out_glyph_q <= e_glyph;
			out_last_q  <= e_last;
		end
	end

	assign out_valid = out_v_q;
	assign cmd       = out_cmd_q;
	assign px        = out_px_q;
	assign py        = out_py_q;
	assign glyph     = out_glyph_q;
	assign last      = out_last_q;

	a_last_show: assert property (@(posedge clk) disable iff (!arst_n)
		out_v_q |-> (out_last_q == (out_cmd_q == CMD_SHOW)))
		else $error("last flag not tied to show command");

	a_scroll_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_v_q && out_cmd_q == CMD_SCROLL) |->
		(out_px_q == 12'd0 && out_py_q == 12'd0 && out_glyph_q == 8'd0))
		else $error("scroll command carries a position");

	a_hide_shown: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_HIDE) |-> shown_q)
		else $error("hide issued while cursor hidden");

	a_show_sets: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && state_q == ST_SHOW) |=> shown_q)
		else $error("cursor flag not set after show");

endmodule

// ===== hdl/text_console_cursor_controller_top.sv =====
// Characters leave the queue while the back end is idle or showing; each then runs hide (if
// the cursor is shown), draw, advance and show, with return and backspace skipping the advance.
// A cell origin step is added after reset, a configuration write or a scroll. Commands are
// registered, the next character is taken during the show, and an output stall holds the sequence.
// reset: cursor at home and hidden, queue empty, registers at their default values
module text_console_cursor_controller_top (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [7:0]                     ch,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [1:0]                     cmd,
	output logic [11:0]                    px,
	output logic [11:0]                    py,
	output logic [7:0]                     glyph,
	output logic                           last,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [tcc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [tcc_pkg::CFG_DATA_W-1:0] cfg_data
);
	import tcc_pkg::*;

	cfg_t    cfg_q;
	q_head_t head;
	logic    pop;
	logic    cfg_wr;

	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid && cfg_ready;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.term_cols <= RST_TERM_COLS;
			cfg_q.term_rows <= RST_TERM_ROWS;
			cfg_q.font_w    <= RST_FONT_W;
			cfg_q.font_h    <= RST_FONT_H;
			cfg_q.screen_w  <= RST_SCREEN_W;
			cfg_q.screen_h  <= RST_SCREEN_H;
			cfg_q.win_x     <= RST_WIN_X;
			cfg_q.win_y     <= RST_WIN_Y;
		end else if (cfg_wr) begin
			unique case (cfg_index)
				REG_TERM_COLS: cfg_q.term_cols <= cfg_data[9:0];
				REG_TERM_ROWS: cfg_q.term_rows <= cfg_data[8:0];
				REG_FONT_W:    cfg_q.font_w    <= cfg_data[5:0];
				REG_FONT_H:    cfg_q.font_h    <= cfg_data[6:0];
				REG_SCREEN_W:  cfg_q.screen_w  <= cfg_data[12:0];
				REG_SCREEN_H:  cfg_q.screen_h  <= cfg_data[12:0];
				REG_WIN_X:     cfg_q.win_x     <= cfg_data[11:0];
				REG_WIN_Y:     cfg_q.win_y     <= cfg_data[11:0];
				default: ;
			endcase
		end
	end

	// character intake and queue
	tcc_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.ch       (ch),
		.pop      (pop),
		.head     (head)
	);

	// cursor sequencer and command output
	tcc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.cfg_wr    (cfg_wr),
		.head      (head),
		.pop       (pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd),
		.px        (px),
		.py        (py),
		.glyph     (glyph),
		.last      (last)
	);

endmodule
